@@ src/ckrd_pkg.sv @@
// Shared types and constants for the keyed rotation decoder.
// Used by the key step unit, the range decoder and the top level.
`default_nettype none

package ckrd_pkg;

	localparam int CpW    = 21;
	localparam int KeyW   = 32;
	localparam int BStepW = 14;
	localparam int EStepW = 11;
	localparam int BOffW  = 15;
	localparam int EOffW  = 11;
	localparam int QuoW   = 19;

	localparam logic [BStepW-1:0] BaseMod  = 14'd10000;
	localparam logic [BOffW-1:0]  BaseSpan = 15'd20976;
	localparam logic [EOffW-1:0]  ExtSpan  = 11'd2000;

	localparam logic [KeyW-1:0] KeyRecip   = 32'hD1B7_1759;
	localparam int              RecipShift = 45;

	localparam logic [CpW-1:0] BaseLo = 21'h004E00;
	localparam logic [CpW-1:0] BaseHi = 21'h009FEF;
	localparam logic [CpW-1:0] ExtLo  = 21'h003400;
	localparam logic [CpW-1:0] ExtEnd = 21'h004B70;

	localparam logic [CpW-1:0] TgtAscii = 21'h000000;
	localparam logic [CpW-1:0] TgtFull  = 21'h00FF00;
	localparam logic [CpW-1:0] TgtPunct = 21'h003000;

	typedef struct packed {
		logic [BStepW-1:0] base;
		logic [EStepW-1:0] ext;
	} step_t;

	typedef enum logic [2:0] {
		WIN_ASCII = 3'b001,
		WIN_FULL  = 3'b010,
		WIN_PUNCT = 3'b100
	} win_t;

	typedef enum logic [3:0] {
		KS_IDLE = 4'b0001,
		KS_MUL  = 4'b0010,
		KS_SUB  = 4'b0100,
		KS_FOLD = 4'b1000
	} key_state_t;

	function automatic logic [CpW-1:0] win_target(input win_t w);
		logic [CpW-1:0] t;
		case (w)
			WIN_ASCII: t = TgtAscii;
			WIN_FULL:  t = TgtFull;
			WIN_PUNCT: t = TgtPunct;
			default:   t = TgtAscii;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

@@ src/ckrd_key_unit.sv @@
// Key step unit: reduces the 32-bit key hash mod 10000 and mod 2000 in steps
// (reciprocal multiply, multiply and subtract, fold). Depends on ckrd_pkg.
`default_nettype none

module ckrd_key_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr,
	input  wire logic [31:0]               key,
	output logic                           busy,
	output ckrd_pkg::step_t                step
);
	import ckrd_pkg::*;

	localparam logic [BStepW-1:0] Ext1 = BStepW'(ExtSpan);
	localparam logic [BStepW-1:0] Ext2 = BStepW'(2 * ExtSpan);
	localparam logic [BStepW-1:0] Ext3 = BStepW'(3 * ExtSpan);
	localparam logic [BStepW-1:0] Ext4 = BStepW'(4 * ExtSpan);

	key_state_t        state_q;
	logic [KeyW-1:0]   key_q;
	logic [QuoW-1:0]   quo_q;
	logic [BStepW-1:0] rb_q;
	logic [EStepW-1:0] re_q;
	logic [2*KeyW-1:0] prod;
	logic [KeyW-1:0]   qmul;
	logic [KeyW-1:0]   rem;
	logic [EStepW-1:0] re_nxt;

	always_comb begin
		prod = (2*KeyW)'(key_q) * (2*KeyW)'(KeyRecip);
		qmul = KeyW'(quo_q) * KeyW'(BaseMod);
		rem  = key_q - qmul;
		if (rb_q >= Ext4) begin
			re_nxt = EStepW'(rb_q - Ext4);
		end else if (rb_q >= Ext3) begin
			re_nxt = EStepW'(rb_q - Ext3);
		end else if (rb_q >= Ext2) begin
			re_nxt = EStepW'(rb_q - Ext2);
		end else if (rb_q >= Ext1) begin
			re_nxt = EStepW'(rb_q - Ext1);
		end else begin
			re_nxt = EStepW'(rb_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KS_IDLE;
			rb_q    <= '0;
			re_q    <= '0;
		end else begin
			case (state_q)
				KS_IDLE: begin
					if (wr) begin
						state_q <= KS_MUL;
					end
				end
				KS_MUL: begin
					state_q <= KS_SUB;
				end
				KS_SUB: begin
					rb_q    <= rem[BStepW-1:0];
					state_q <= KS_FOLD;
				end
				KS_FOLD: begin
					re_q    <= re_nxt;
					state_q <= KS_IDLE;
				end
				default: begin
					state_q <= KS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			key_q <= key;
		end
		if (state_q == KS_MUL) begin
			quo_q <= prod[RecipShift+QuoW-1:RecipShift];
		end
	end

	assign busy      = (state_q != KS_IDLE);
	assign step.base = rb_q;
	assign step.ext  = re_q;

endmodule

`default_nettype wire

@@ src/ckrd_decode.sv @@
// Range decoder: rotates a code point back by the current offsets in its range.
// Depends on ckrd_pkg.
`default_nettype none

module ckrd_decode (
	input  wire logic [20:0] cp,
	input  wire logic [14:0] boff,
	input  wire logic [10:0] eoff,
	output logic      [20:0] plain,
	output logic             mapped
);
	import ckrd_pkg::*;

	logic              in_base;
	logic              in_ext;
	logic [BOffW-1:0]  rel_b;
	logic [BOffW:0]    d_b;
	logic [BOffW-1:0]  res_b;
	logic [12:0]       rel_e;
	win_t              win;
	logic [12:0]       win_base;
	logic [EOffW-1:0]  pos_e;
	logic [EOffW:0]    d_e;
	logic [EOffW-1:0]  res_e;

	always_comb begin
		in_base = (cp >= BaseLo) && (cp <= BaseHi);
		in_ext  = (cp >= ExtLo) && (cp < ExtEnd);

		rel_b = BOffW'(cp - BaseLo);
		d_b   = {1'b0, rel_b} - {1'b0, boff};
		res_b = d_b[BOffW] ? BOffW'(d_b + {1'b0, BaseSpan}) : d_b[BOffW-1:0];

		rel_e = 13'(cp - ExtLo);
		if (rel_e < 13'd2000) begin
			win = WIN_ASCII;
			win_base = 13'd0;
		end else if (rel_e < 13'd4000) begin
			win = WIN_FULL;
			win_base = 13'd2000;
		end else begin
			win = WIN_PUNCT;
			win_base = 13'd4000;
		end
		pos_e = EOffW'(rel_e - win_base);
		d_e   = {1'b0, pos_e} - {1'b0, eoff};
		res_e = d_e[EOffW] ? EOffW'(d_e + {1'b0, ExtSpan}) : d_e[EOffW-1:0];

		if (in_base) begin
			plain  = BaseLo + CpW'(res_b);
			mapped = 1'b1;
		end else if (in_ext) begin
			plain  = win_target(win) + CpW'(res_e);
			mapped = 1'b1;
		end else begin
			plain  = cp;
			mapped = 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ src/cjk_keyed_rotation_decoder.sv @@
// Top level of the keyed rotation decoder: offset tracking, input and result stages.
// Depends on ckrd_pkg, ckrd_key_unit and ckrd_decode.
`default_nettype none

// Decodes one code point per cycle unless stalled, through an input stage and a
// result stage; result_stall back-pressures through a one-deep input stage.
// Both running offsets advance by one modular add at the beat an item is
// taken, and return to zero after an item marked last_of_text. A write of
// key_hash starts a reduction of the key mod 10000 and mod 2000; cfg_ready is
// low and item_stall high during it.
module cjk_keyed_rotation_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] key_hash,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [20:0] code_point,
	input  wire logic        last_of_text,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic      [20:0] plain_point,
	output logic             mapped
);
	import ckrd_pkg::*;

	step_t            step;
	logic             key_busy;
	logic             accept;
	logic             out_take;
	logic             s1_ready;
	logic [BOffW-1:0] boff_q;
	logic [EOffW-1:0] eoff_q;
	logic [BOffW:0]   bsum;
	logic [EOffW:0]   esum;
	logic [BOffW-1:0] boff_adv;
	logic [EOffW-1:0] eoff_adv;
	logic             valid_s1;
	logic [CpW-1:0]   cp_s1;
	logic [BOffW-1:0] boff_s1;
	logic [EOffW-1:0] eoff_s1;
	logic             valid_s2;
	logic [CpW-1:0]   plain_s2;
	logic             mapped_s2;
	logic [CpW-1:0]   dec_plain;
	logic             dec_mapped;

	ckrd_key_unit u_key (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_valid && cfg_ready),
		.key    (key_hash),
		.busy   (key_busy),
		.step   (step)
	);

	ckrd_decode u_dec (
		.cp     (cp_s1),
		.boff   (boff_s1),
		.eoff   (eoff_s1),
		.plain  (dec_plain),
		.mapped (dec_mapped)
	);

	assign cfg_ready  = !key_busy;
	assign out_take   = !valid_s2 || !result_stall;
	assign s1_ready   = !valid_s1 || out_take;
	assign item_stall = key_busy || !s1_ready;
	assign accept     = item_valid && !item_stall;

	always_comb begin
		bsum = {1'b0, boff_q} + (BOffW+1)'(step.base);
		esum = {1'b0, eoff_q} + (EOffW+1)'(step.ext);
		boff_adv = (bsum >= {1'b0, BaseSpan}) ? BOffW'(bsum - {1'b0, BaseSpan})
			: bsum[BOffW-1:0];
		eoff_adv = (esum >= {1'b0, ExtSpan}) ? EOffW'(esum - {1'b0, ExtSpan})
			: esum[EOffW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boff_q   <= '0;
			eoff_q   <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				boff_q <= last_of_text ? '0 : boff_adv;
				eoff_q <= last_of_text ? '0 : eoff_adv;
			end
			if (s1_ready) begin
				valid_s1 <= accept;
			end
			if (out_take) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cp_s1   <= code_point;
			boff_s1 <= boff_adv;
			eoff_s1 <= eoff_adv;
		end
		if (out_take && valid_s1) begin
			plain_s2  <= dec_plain;
			mapped_s2 <= dec_mapped;
		end
	end

	assign result_valid = valid_s2;
	assign plain_point  = plain_s2;
	assign mapped       = mapped_s2;

endmodule

`default_nettype wire

@@ src/ckrd_checker.sv @@
// Port-level checker for the keyed rotation decoder, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module ckrd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic        item_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [20:0] plain_point,
	input wire logic        mapped
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(plain_point) && $stable(mapped))
		else $error("stalled result beat changed");

	a_mapped_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && mapped |->
			(plain_point >= 21'h004E00 && plain_point <= 21'h009FEF) ||
			(plain_point <= 21'h0007CF) ||
			(plain_point >= 21'h00FF00 && plain_point <= 21'h0106CF) ||
			(plain_point >= 21'h003000 && plain_point <= 21'h0037CF))
		else $error("mapped result outside decoded targets");

	a_cfg_blocks_items: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> item_stall)
		else $error("item taken during key reduction");

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !cfg_ready)
		else $error("key write taken during key reduction");

endmodule

bind cjk_keyed_rotation_decoder ckrd_checker u_ckrd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.plain_point  (plain_point),
	.mapped       (mapped)
);

`default_nettype wire
